// ===== design/osc_pkg.sv =====
// Package for the opto-style stereo compressor.
// Holds widths, register indexes, sequencer step codes, command struct and the exp2 root table.
// No dependencies.
package osc_pkg;

  localparam int SB = 24;
  localparam int CB = 24;
  localparam int MK_BITS = 23;
  localparam int ROOTS = 12;
  localparam int LOG_FRAC = 16;

  localparam logic [2:0] REG_THR = 3'd0;
  localparam logic [2:0] REG_MAKEUP = 3'd1;
  localparam logic [2:0] REG_LIMIT = 3'd2;
  localparam logic [2:0] REG_FAST_ATT = 3'd3;
  localparam logic [2:0] REG_FAST_REL = 3'd4;
  localparam logic [2:0] REG_SLOW_ATT = 3'd5;
  localparam logic [2:0] REG_SLOW_REL = 3'd6;
  localparam logic [2:0] REG_METER = 3'd7;

  typedef enum logic [4:0] {
    OP_IDLE, OP_F1, OP_F2, OP_S1, OP_S2, OP_M1, OP_M2,
    OP_LN_M, OP_LSQ_M, OP_LN_T, OP_LSQ_T, OP_OVER, OP_GR1, OP_GR2,
    OP_EXP, OP_ROOT, OP_SHIFT, OP_GAIN, OP_OL, OP_OR, OP_MT1, OP_MT2, OP_DONE
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [3:0] iter;
    logic       accept;
    logic       load_out;
  } cmd_t;

  // 2^(-2^-(k+1)) in Q1.30
  function automatic logic [29:0] root_q30(input logic [3:0] k);
    logic [29:0] r;
    unique case (k)
      4'd0:    r = 30'd759250125;
      4'd1:    r = 30'd902905651;
      4'd2:    r = 30'd984625594;
      4'd3:    r = 30'd1028218693;
      4'd4:    r = 30'd1050733751;
      4'd5:    r = 30'd1062175491;
      4'd6:    r = 30'd1067942999;
      4'd7:    r = 30'd1070838486;
      4'd8:    r = 30'd1072289173;
      4'd9:    r = 30'd1073015252;
      4'd10:   r = 30'd1073378477;
      4'd11:   r = 30'd1073560135;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== design/osc_ctrl.sv =====
// Sequencer for the compressor: steps the datapath through one sample pair.
// Depends on osc_pkg.
module osc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output osc_pkg::cmd_t cmd_o
);
  import osc_pkg::*;

  op_e        state_q, state_d;
  logic [3:0] iter_q, iter_d;
  logic       ovalid_q, ovalid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= OP_IDLE;
      iter_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      iter_q   <= iter_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    iter_d = iter_q;
    cmd_o.op = state_q;
    cmd_o.iter = iter_q;
    cmd_o.accept = 1'b0;
    cmd_o.load_out = 1'b0;
    s_axis_tready = 1'b0;
    unique case (state_q)
      OP_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd_o.accept = 1'b1;
          state_d = OP_F1;
        end
      end
      OP_F1:    state_d = OP_F2;
      OP_F2:    state_d = OP_S1;
      OP_S1:    state_d = OP_S2;
      OP_S2:    state_d = OP_M1;
      OP_M1:    state_d = OP_M2;
      OP_M2:    state_d = OP_LN_M;
      OP_LN_M: begin
        state_d = OP_LSQ_M;
        iter_d = '0;
      end
      OP_LSQ_M: begin
        iter_d = iter_q + 4'd1;
        if (iter_q == 4'(LOG_FRAC - 1)) state_d = OP_LN_T;
      end
      OP_LN_T: begin
        state_d = OP_LSQ_T;
        iter_d = '0;
      end
      OP_LSQ_T: begin
        iter_d = iter_q + 4'd1;
        if (iter_q == 4'(LOG_FRAC - 1)) state_d = OP_OVER;
      end
      OP_OVER:  state_d = OP_GR1;
      OP_GR1:   state_d = OP_GR2;
      OP_GR2:   state_d = OP_EXP;
      OP_EXP: begin
        state_d = OP_ROOT;
        iter_d = '0;
      end
      OP_ROOT: begin
        iter_d = iter_q + 4'd1;
        if (iter_q == 4'(ROOTS - 1)) state_d = OP_SHIFT;
      end
      OP_SHIFT: state_d = OP_GAIN;
      OP_GAIN:  state_d = OP_OL;
      OP_OL:    state_d = OP_OR;
      OP_OR:    state_d = OP_MT1;
      OP_MT1:   state_d = OP_MT2;
      OP_MT2:   state_d = OP_DONE;
      OP_DONE: begin
        if (!ovalid_q || m_axis_tready) begin
          cmd_o.load_out = 1'b1;
          state_d = OP_IDLE;
        end
      end
      default:  state_d = OP_IDLE;
    endcase
    ovalid_d = ovalid_q;
    if (m_axis_tready) ovalid_d = 1'b0;
    if (cmd_o.load_out) ovalid_d = 1'b1;
  end

  assign m_axis_tvalid = ovalid_q;

endmodule

// ===== design/osc_datapath.sv =====
// Datapath for the compressor: config registers, envelopes, one shared multiplier, output register.
// Depends on osc_pkg; driven by osc_ctrl commands.
module osc_datapath (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  osc_pkg::cmd_t           cmd_i,
  input  logic [osc_pkg::SB-1:0]  left_in_i,
  input  logic [osc_pkg::SB-1:0]  right_in_i,
  input  logic                    cfg_we_i,
  input  logic [2:0]              cfg_idx_i,
  input  logic [23:0]             cfg_data_i,
  output logic [osc_pkg::SB-1:0]  left_out_o,
  output logic [osc_pkg::SB-1:0]  right_out_o,
  output logic [15:0]             reduction_db_o,
  output logic [osc_pkg::SB-2:0]  output_level_o
);
  import osc_pkg::*;

  localparam logic [CB:0] ONE_C = (CB + 1)'(1) << CB;
  localparam logic [SB-1:0] HALF_S = SB'(1) << (SB - 1);

  logic [SB-1:0] thr_q;
  logic [MK_BITS-1:0] mk_q;
  logic lim_q;
  logic [CB-1:0] fa_q, fr_q, sa_q, sr_q, mc_q;
  logic [SB-1:0] fenv_q, senv_q, oenv_q;

  logic [SB-1:0] l_q, r_q, la_q, ra_q, mix_q;
  logic [48:0] acc_q;
  logic [30:0] m_q;
  logic [4:0] p_q;
  logic [15:0] frac_q;
  logic [20:0] lgm_q;
  logic [24:0] over_q, gr_q;
  logic exc_q, kn_q;
  logic [19:0] e_q;
  logic [30:0] lin_q;
  logic [23:0] g_q;
  logic [SB-1:0] lo_q, ro_q, lm_q, rm_q;

  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic [SB-1:0] x_in;
  logic [CB-1:0] fc, sc;
  logic [49:0] pole_sum;
  logic [SB-1:0] norm_v;
  logic [4:0] norm_p;
  logic [31:0] sq;
  logic [20:0] diff;
  logic [3:0] bit_idx;
  logic [11:0] ef;
  logic [32:0] gain_r;
  logic [SB-1:0] gain_mag, gain_out;
  logic gain_neg;
  logic [SB-1:0] peak;
  logic [26:0] over3;
  logic [25:0] red_sum;

  // stereo-linked peak of the pair held since the input transfer
  assign x_in = (la_q > ra_q) ? la_q : ra_q;
  assign fc = (x_in > fenv_q) ? fa_q : fr_q;
  assign sc = (x_in > senv_q) ? sa_q : sr_q;
  assign peak = (lm_q > rm_q) ? lm_q : rm_q;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd_i.op)
      OP_F1:    begin mul_a = 32'(fc); mul_b = 32'(fenv_q); end
      OP_F2:    begin mul_a = 32'(ONE_C - (CB + 1)'(fc)); mul_b = 32'(x_in); end
      OP_S1:    begin mul_a = 32'(sc); mul_b = 32'(senv_q); end
      OP_S2:    begin mul_a = 32'(ONE_C - (CB + 1)'(sc)); mul_b = 32'(x_in); end
      OP_M1:    begin mul_a = 32'd45875; mul_b = 32'(fenv_q); end
      OP_M2:    begin mul_a = 32'd19661; mul_b = 32'(senv_q); end
      OP_LSQ_M, OP_LSQ_T: begin mul_a = 32'(m_q); mul_b = 32'(m_q); end
      OP_OVER:  begin mul_a = 32'(diff); mul_b = 32'd394566; end
      OP_GR1:   begin mul_a = 32'(over_q); mul_b = 32'(over_q); end
      OP_GR2:   begin mul_a = 32'(gr_q); mul_b = 32'd1398102; end
      OP_EXP:   begin mul_a = 32'(gr_q); mul_b = 32'd10885; end
      OP_ROOT:  begin mul_a = 32'(lin_q); mul_b = 32'(root_q30(cmd_i.iter)); end
      OP_GAIN:  begin mul_a = 32'(lin_q); mul_b = 32'(mk_q); end
      OP_OL:    begin mul_a = 32'(la_q); mul_b = 32'(g_q); end
      OP_OR:    begin mul_a = 32'(ra_q); mul_b = 32'(g_q); end
      OP_MT1:   begin mul_a = 32'(mc_q); mul_b = 32'(oenv_q); end
      OP_MT2:   begin mul_a = 32'(ONE_C - (CB + 1)'(mc_q)); mul_b = 32'(peak); end
      default:  begin mul_a = '0; mul_b = '0; end
    endcase
  end

  assign prod = 64'(mul_a) * 64'(mul_b);
  assign pole_sum = 50'(acc_q) + 50'(prod[48:0]) + (50'(1) << (CB - 1));

  // log2 normalization
  always_comb begin
    norm_v = (cmd_i.op == OP_LN_T) ? ((thr_q == '0) ? SB'(1) : thr_q) : mix_q;
    norm_p = '0;
    for (int i = 0; i < SB; i++) begin
      if (norm_v[i]) norm_p = 5'(i);
    end
  end

  assign sq = prod[61:30];
  assign diff = lgm_q - {p_q, frac_q};
  assign ef = e_q[11:0];
  assign bit_idx = 4'(ROOTS - 1) - cmd_i.iter;
  assign over3 = 27'(over_q) + {1'b0, over_q, 1'b0};

  always_comb begin
    gain_neg = (cmd_i.op == OP_OL) ? l_q[SB-1] : r_q[SB-1];
    gain_r = 33'(prod[47:0] + 48'd32768 >> 16);
    if (gain_neg) begin
      gain_mag = (gain_r > 33'(HALF_S)) ? HALF_S : gain_r[SB-1:0];
      gain_out = SB'(0) - gain_mag;
    end else begin
      gain_mag = (gain_r > 33'(HALF_S - SB'(1))) ? (HALF_S - SB'(1)) : gain_r[SB-1:0];
      gain_out = gain_mag;
    end
  end

  assign red_sum = 26'(gr_q) + 26'd32;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= SB'(8388608);
      mk_q   <= MK_BITS'(65536);
      lim_q  <= 1'b0;
      fa_q   <= CB'(16603354);
      fr_q   <= CB'(16771392);
      sa_q   <= CB'(16742301);
      sr_q   <= CB'(16776983);
      mc_q   <= CB'(16776051);
      fenv_q <= '0;
      senv_q <= '0;
      oenv_q <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_THR:      thr_q <= cfg_data_i[SB-1:0];
          REG_MAKEUP:   mk_q <= cfg_data_i[MK_BITS-1:0];
          REG_LIMIT:    lim_q <= cfg_data_i[0];
          REG_FAST_ATT: fa_q <= cfg_data_i[CB-1:0];
          REG_FAST_REL: fr_q <= cfg_data_i[CB-1:0];
          REG_SLOW_ATT: sa_q <= cfg_data_i[CB-1:0];
          REG_SLOW_REL: sr_q <= cfg_data_i[CB-1:0];
          REG_METER:    mc_q <= cfg_data_i[CB-1:0];
          default: ;
        endcase
      end
      if (cmd_i.op == OP_F2) fenv_q <= pole_sum[CB+SB-1:CB];
      if (cmd_i.op == OP_S2) senv_q <= pole_sum[CB+SB-1:CB];
      if (cmd_i.op == OP_MT2) oenv_q <= pole_sum[CB+SB-1:CB];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      l_q  <= left_in_i;
      r_q  <= right_in_i;
      la_q <= left_in_i[SB-1] ? (SB'(0) - left_in_i) : left_in_i;
      ra_q <= right_in_i[SB-1] ? (SB'(0) - right_in_i) : right_in_i;
    end
    unique case (cmd_i.op)
      OP_F1, OP_S1, OP_M1, OP_MT1: acc_q <= prod[48:0];
      OP_M2: mix_q <= 24'((50'(acc_q) + 50'(prod[48:0]) + 50'd32768) >> 16);
      OP_LN_M, OP_LN_T: begin
        if (cmd_i.op == OP_LN_T) lgm_q <= {p_q, frac_q};
        p_q    <= norm_p;
        m_q    <= 31'({norm_v, 7'd0} << (5'(SB - 1) - norm_p));
        frac_q <= '0;
      end
      OP_LSQ_M, OP_LSQ_T: begin
        if (sq[31]) begin
          m_q    <= sq[31:1];
          frac_q <= {frac_q[14:0], 1'b1};
        end else begin
          m_q    <= sq[30:0];
          frac_q <= {frac_q[14:0], 1'b0};
        end
      end
      OP_OVER: begin
        over_q <= 25'((prod[40:0] + 41'd32768) >> 16);
        exc_q  <= mix_q > thr_q;
      end
      OP_GR1: begin
        kn_q <= 1'b0;
        if (!exc_q) gr_q <= '0;
        else if (lim_q) gr_q <= over_q;
        else if (over_q >= 25'd393216) gr_q <= over3[26:2];
        else begin
          gr_q <= 25'((prod[38:0] + 39'd393216) >> 18);
          kn_q <= 1'b1;
        end
      end
      OP_GR2: if (kn_q) gr_q <= 25'(prod[45:22]);
      OP_EXP: begin
        e_q   <= 20'((prod[39:0] + 40'd524288) >> 20);
        lin_q <= 31'(1) << 30;
      end
      OP_ROOT: if (ef[bit_idx]) lin_q <= 31'((prod[60:0] + 61'd536870912) >> 30);
      OP_SHIFT: lin_q <= (e_q[19:12] >= 8'd31) ? '0 : (lin_q >> e_q[16:12]);
      OP_GAIN: g_q <= 24'((prod[53:0] + 54'd536870912) >> 30);
      OP_OL: begin lo_q <= gain_out; lm_q <= gain_mag; end
      OP_OR: begin ro_q <= gain_out; rm_q <= gain_mag; end
      default: ;
    endcase
    if (cmd_i.load_out) begin
      left_out_o     <= lo_q;
      right_out_o    <= ro_q;
      reduction_db_o <= (red_sum[25:6] > 20'd65535) ? 16'hFFFF : red_sum[21:6];
      output_level_o <= (oenv_q > {1'b0, {(SB-1){1'b1}}}) ? {(SB-1){1'b1}} : oenv_q[SB-2:0];
    end
  end

endmodule

// ===== design/opto_style_stereo_compressor.sv =====
// Top level of the opto-style stereo compressor.
// Instantiates osc_ctrl and osc_datapath; depends on osc_pkg.
//
// Input stream: one stereo pair per transfer, tdata = left_in, right_in.
// Output stream: one result per pair, tdata = left_out, right_out,
// reduction_db, output_level, zero padded to 88 bits.
// Config: write cfg_we_i with cfg_idx_i and cfg_data_i, only while idle.
// A new pair is taken in the cycle after the result is loaded, so no new
// pair is taken while one is in process. The sequence is long because the
// single shared 32x32 multiplier is used by two 16-step log2 squaring
// loops and a 12-step exp2 root loop.
// A finished result waits in the output register; the next pair is taken
// and processed meanwhile, and the sequencer holds in its last step until
// the receiver takes the waiting result.
// Reset clears envelopes, loads register defaults and drops m_axis_tvalid.
module opto_style_stereo_compressor (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // left_in[23:0], right_in[47:24]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [87:0] m_axis_tdata,  // left_out, right_out, reduction_db, output_level, pad
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [23:0] cfg_data_i
);
  import osc_pkg::*;

  cmd_t cmd;
  logic [SB-1:0] left_out, right_out;
  logic [15:0] reduction_db;
  logic [SB-2:0] output_level;

  osc_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .m_axis_tvalid,
    .m_axis_tready,
    .cmd_o (cmd)
  );

  osc_datapath u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i          (cmd),
    .left_in_i      (s_axis_tdata[23:0]),
    .right_in_i     (s_axis_tdata[47:24]),
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .left_out_o     (left_out),
    .right_out_o    (right_out),
    .reduction_db_o (reduction_db),
    .output_level_o (output_level)
  );

  assign m_axis_tdata = {1'b0, output_level, reduction_db, right_out, left_out};

endmodule

// ===== design/osc_checker.sv =====
// Port-level checks for the compressor, bound to the top level.
// Depends on opto_style_stereo_compressor ports only.
module osc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [87:0] m_axis_tdata
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled output changed");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while busy");

  a_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> s_axis_tready)
    else $error("result loaded while not returning to idle");

  a_pad: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !m_axis_tdata[87])
    else $error("pad bit set");

endmodule

bind opto_style_stereo_compressor osc_checker u_osc_checker (
  .clk_i,
  .rst_ni,
  .s_axis_tvalid,
  .s_axis_tready,
  .m_axis_tvalid,
  .m_axis_tready,
  .m_axis_tdata
);

// ===== tb/testbench.sv =====
// Self-checking testbench for opto_style_stereo_compressor.
// It predicts every output transfer with a fixed-point model of the compressor and
// compares it field by field. Depends on osc_pkg and the design sources.
module testbench;
  import osc_pkg::*;

  localparam int LIMIT_CYCLES = 3000000;

  // packed from the top bit down, so left_out lands in the low bits of tdata
  typedef struct packed {
    logic [22:0] output_level;
    logic [15:0] reduction_db;
    logic [23:0] right_out;
    logic [23:0] left_out;
  } gained_pair_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [87:0] m_axis_tdata;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [23:0] cfg_data_i = '0;

  opto_style_stereo_compressor i_dut (.*);

  always #10 clk_i = ~clk_i;

  // model registers and envelopes
  logic [63:0] thr_q, makeup_q, limit_q, fatt_q, frel_q, satt_q, srel_q, meter_q;
  logic [63:0] fast_env, slow_env, out_env;

  gained_pair_t expected_pairs[$];
  int  fail_count = 0;
  int  pairs_checked = 0;
  int  cycle_count = 0;
  int  stall_pct = 0;

  localparam logic [63:0] ROOT_TAB [12] = '{
    64'd759250125, 64'd902905651, 64'd984625594, 64'd1028218693,
    64'd1050733751, 64'd1062175491, 64'd1067942999, 64'd1070838486,
    64'd1072289173, 64'd1073015252, 64'd1073378477, 64'd1073560135};

  function automatic logic [63:0] pole_step(logic [63:0] c, logic [63:0] env,
                                            logic [63:0] x);
    return (c * env + ((64'd1 << 24) - c) * x + (64'd1 << 23)) >> 24;
  endfunction

  function automatic logic [63:0] log2_fix(logic [63:0] v);
    int p;
    logic [63:0] m, frac;
    p = 0;
    frac = 0;
    while (p < 63 && (v >> (p + 1)) != 0) p++;
    m = (p <= 30) ? (v << (30 - p)) : (v >> (p - 30));
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        frac = frac | 64'd1;
      end
    end
    return (64'(p) << 16) | frac;
  endfunction

  function automatic logic [63:0] abs_sample(logic [23:0] v);
    return v[23] ? ((64'd1 << 24) - 64'(v)) : 64'(v);
  endfunction

  function automatic logic [23:0] gain_sample(logic [23:0] v, logic [63:0] g,
                                              output logic [63:0] mag);
    logic [63:0] r;
    r = (abs_sample(v) * g + 64'd32768) >> 16;
    if (v[23]) begin
      if (r > (64'd1 << 23)) r = 64'd1 << 23;
      mag = r;
      return 24'((64'd1 << 24) - r);
    end
    if (r > (64'd1 << 23) - 1) r = (64'd1 << 23) - 1;
    mag = r;
    return r[23:0];
  endfunction

  function automatic gained_pair_t predict_pair(logic [23:0] l, logic [23:0] r);
    gained_pair_t res;
    logic [63:0] la, ra, x, mix, thr, over, gr, e, lin, g, lm, rm, red;
    la = abs_sample(l);
    ra = abs_sample(r);
    x = la > ra ? la : ra;
    fast_env = pole_step(x > fast_env ? fatt_q : frel_q, fast_env, x);
    slow_env = pole_step(x > slow_env ? satt_q : srel_q, slow_env, x);
    mix = (64'd45875 * fast_env + 64'd19661 * slow_env + 64'd32768) >> 16;
    thr = thr_q == 0 ? 64'd1 : thr_q;
    gr = 0;
    if (mix > thr_q) begin
      over = ((log2_fix(mix) - log2_fix(thr)) * 64'd394566 + 64'd32768) >> 16;
      if (limit_q[0]) gr = over;
      else if (over < 64'd393216) gr = (over * over + 64'd393216) / 64'd786432;
      else gr = (64'd3 * over) >> 2;
    end
    e = (gr * 64'd10885 + (64'd1 << 19)) >> 20;
    lin = 64'd1 << 30;
    for (int k = 0; k < 12; k++)
      if (e[11-k]) lin = (lin * ROOT_TAB[k] + (64'd1 << 29)) >> 30;
    lin = (e >> 12) >= 31 ? 64'd0 : (lin >> (e >> 12));
    g = (lin * makeup_q + (64'd1 << 29)) >> 30;
    res.left_out = gain_sample(l, g, lm);
    res.right_out = gain_sample(r, g, rm);
    out_env = pole_step(meter_q, out_env, lm > rm ? lm : rm);
    red = (gr + 32) >> 6;
    res.reduction_db = red > 65535 ? 16'hffff : red[15:0];
    res.output_level = out_env > 64'h7fffff ? 23'h7fffff : out_env[22:0];
    return res;
  endfunction

  // output side: random stall and result check
  always @(posedge clk_i) begin
    gained_pair_t got, exp_pair;
    if (m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[86:0];
      if (expected_pairs.size() == 0) begin
        $error("unexpected output transfer %h", m_axis_tdata);
        fail_count++;
      end else begin
        exp_pair = expected_pairs.pop_front();
        pairs_checked++;
        if (got.left_out !== exp_pair.left_out) begin
          $error("left_out exp %h got %h", exp_pair.left_out, got.left_out);
          fail_count++;
        end
        if (got.right_out !== exp_pair.right_out) begin
          $error("right_out exp %h got %h", exp_pair.right_out, got.right_out);
          fail_count++;
        end
        if (got.reduction_db !== exp_pair.reduction_db) begin
          $error("reduction_db exp %h got %h", exp_pair.reduction_db, got.reduction_db);
          fail_count++;
        end
        if (got.output_level !== exp_pair.output_level) begin
          $error("output_level exp %h got %h", exp_pair.output_level, got.output_level);
          fail_count++;
        end
      end
    end
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_pair(logic [23:0] l, logic [23:0] r, int idle_pct);
    if ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 90)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {r, l};
    do @(posedge clk_i); while (!s_axis_tready);
    expected_pairs.push_back(predict_pair(l, r));
  endtask

  task automatic wait_drain();
    s_axis_tvalid <= 1'b0;
    while (expected_pairs.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [23:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      REG_THR:      thr_q = 64'(val);
      REG_MAKEUP:   makeup_q = 64'(val[22:0]);
      REG_LIMIT:    limit_q = 64'(val[0]);
      REG_FAST_ATT: fatt_q = 64'(val);
      REG_FAST_REL: frel_q = 64'(val);
      REG_SLOW_ATT: satt_q = 64'(val);
      REG_SLOW_REL: srel_q = 64'(val);
      default:      meter_q = 64'(val);
    endcase
  endtask

  function automatic logic [23:0] rand_sample();
    case ($urandom_range(5))
      0: return 24'($urandom);
      1: return $urandom_range(1) ? 24'h7fffff - 24'($urandom_range(4095))
                                  : 24'h800000 + 24'($urandom_range(4095));
      2: return 24'($signed(12'($urandom)));
      3: return $urandom_range(1) ? 24'h800000 : 24'h7fffff;
      default: return 24'($urandom_range(8388607));
    endcase
  endfunction

  function automatic logic [23:0] rand_coeff();
    case ($urandom_range(4))
      0: return 24'd0;
      1: return 24'hffffff;
      2: return 24'($urandom);
      default: return 24'hffffff - 24'($urandom_range(1 << 20));
    endcase
  endfunction

  task automatic random_config();
    case ($urandom_range(3))
      0: write_reg(REG_THR, 24'd0);
      1: write_reg(REG_THR, 24'h800000);
      2: write_reg(REG_THR, 24'($urandom_range(8388608)));
      default: write_reg(REG_THR, 24'($urandom_range(65535)));
    endcase
    write_reg(REG_MAKEUP, $urandom_range(1) ? 24'($urandom) : 24'($urandom_range(262143)));
    write_reg(REG_LIMIT, 24'($urandom));
    write_reg(REG_FAST_ATT, rand_coeff());
    write_reg(REG_FAST_REL, rand_coeff());
    write_reg(REG_SLOW_ATT, rand_coeff());
    write_reg(REG_SLOW_REL, rand_coeff());
    write_reg(REG_METER, rand_coeff());
  endtask

  task automatic test_defaults();
    send_pair(24'h000000, 24'h000000, 0);
    send_pair(24'h7fffff, 24'h800000, 0);
    send_pair(24'h800000, 24'h7fffff, 0);
    send_pair(24'h000001, 24'hffffff, 0);
    wait_drain();
  endtask

  task automatic test_extreme_config();
    write_reg(REG_FAST_ATT, 24'd0);
    write_reg(REG_FAST_REL, 24'd0);
    write_reg(REG_SLOW_ATT, 24'd0);
    write_reg(REG_SLOW_REL, 24'd0);
    write_reg(REG_METER, 24'd0);
    write_reg(REG_THR, 24'h001000);
    write_reg(REG_MAKEUP, 24'hffffff);
    send_pair(24'h7fffff, 24'h000100, 0);
    send_pair(24'h000fff, 24'h801000, 0);
    send_pair(24'h400000, 24'hc00000, 0);
    wait_drain();
    write_reg(REG_LIMIT, 24'hfffffe);
    send_pair(24'h100000, 24'h010000, 0);
    send_pair(24'h7fffff, 24'h800000, 0);
    wait_drain();
    write_reg(REG_LIMIT, 24'h000001);
    write_reg(REG_THR, 24'd0);
    write_reg(REG_MAKEUP, 24'd0);
    send_pair(24'h000001, 24'h000000, 0);
    send_pair(24'h800000, 24'h000000, 0);
    wait_drain();
    write_reg(REG_THR, 24'h800000);
    write_reg(REG_MAKEUP, 24'h7fffff);
    write_reg(REG_FAST_ATT, 24'hffffff);
    write_reg(REG_SLOW_REL, 24'hffffff);
    write_reg(REG_METER, 24'hffffff);
    send_pair(24'h7fffff, 24'h7fffff, 0);
    send_pair(24'h800000, 24'h800000, 0);
    send_pair(24'h000010, 24'hfffff0, 0);
    wait_drain();
  endtask

  task automatic test_random_phase(int idle_pct, int stall, int count);
    stall_pct = stall;
    random_config();
    for (int i = 0; i < count; i++) begin
      // bursts of loud or quiet material drive attack and release
      if ($urandom_range(9) < 8) begin
        logic [23:0] amp;
        amp = $urandom_range(1) ? 24'h7fffff : 24'($urandom_range(65535));
        for (int j = 0; j < 8 && i < count; j++, i++)
          send_pair(24'(rand_sample() & (amp | 24'h800000 * $urandom_range(1))),
                    rand_sample(), idle_pct);
        i--;
      end else begin
        send_pair(rand_sample(), rand_sample(), idle_pct);
      end
      if (i == count / 2) wait_drain();
    end
    wait_drain();
    stall_pct = 0;
  endtask

  initial begin
    thr_q = 64'd8388608;   makeup_q = 64'd65536; limit_q = 0;
    fatt_q = 64'd16603354; frel_q = 64'd16771392;
    satt_q = 64'd16742301; srel_q = 64'd16776983; meter_q = 64'd16776051;
    fast_env = 0; slow_env = 0; out_env = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_defaults();
    test_extreme_config();
    test_random_phase(0, 0, 290);
    test_random_phase(68, 0, 280);
    test_random_phase(0, 68, 290);
    test_random_phase(28, 28, 290);
    $display("Checked %0d output transfers over directed extremes and four idle/stall phases",
             pairs_checked);
    $display("with random thresholds, makeup gains, modes and envelope poles.");
    if (fail_count == 0 && expected_pairs.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
